>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

>>> hw/rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Types and fixed constants shared by the page allocator modules.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int STORE_DEPTH = 32768;
    localparam int PAGE_W      = 15;
    localparam int FCOUNT_W    = 16;
    localparam int RCOUNT_W    = 8;

    localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADDREF = 2'd2,
        OP_SPLIT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_COUNT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SPLIT
    } bk_state_t;

    typedef struct packed {
        op_t               op;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] page_idx;
        logic              out_of_range;
    } cmd_t;

endpackage

>>> hw/rtl/rpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rpa_front.sv
// ----------------------------------------------------------------------------
// Page allocator front end
// Accepts request words, decodes the operation and checks the page range.
// ----------------------------------------------------------------------------
module rpa_front #(
    parameter int FIRST_PAGE = 256,
    parameter int USABLE_END = 32768
) (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [rpa_pkg::PAGE_W-1:0]  s_page,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output rpa_pkg::cmd_t               cmd
);

    logic lo_ok;
    logic hi_ok;

    assign lo_ok = 32'(s_page) >= 32'(FIRST_PAGE);
    assign hi_ok = 32'(s_page) < 32'(USABLE_END);

    always_comb begin
        cmd.op           = rpa_pkg::op_t'(s_operation);
        cmd.page         = s_page;
        cmd.page_idx     = s_page - rpa_pkg::PAGE_W'(FIRST_PAGE);
        cmd.out_of_range = !(lo_ok && hi_ok);
    end

    assign cmd_valid = s_valid;
    assign s_ready   = cmd_ready;

endmodule

>>> hw/rtl/rpa_queue.sv
// ----------------------------------------------------------------------------
// Page allocator command queue
// Two-entry queue that decouples request decode from execution.
// ----------------------------------------------------------------------------
module rpa_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rpa_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rpa_pkg::cmd_t rd_data
);

    rpa_pkg::cmd_t entries_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    logic          pop;

    assign wr_ready = fill_reg != 2'd2;
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/rpa_back.sv
// ----------------------------------------------------------------------------
// Page allocator back end
// Executes commands against the free stack and reference count memories.
// ----------------------------------------------------------------------------
module rpa_back #(
    parameter int FIRST_PAGE = 256,
    parameter int INIT_COUNT = 32512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rpa_pkg::cmd_t                 cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpa_pkg::PAGE_W-1:0]    m_result_page,
    output logic [1:0]                    m_status,
    output logic                          m_released,
    output logic [rpa_pkg::FCOUNT_W-1:0]  free_count
);

    localparam int PW = rpa_pkg::PAGE_W;
    localparam int FW = rpa_pkg::FCOUNT_W;
    localparam int RW = rpa_pkg::RCOUNT_W;

    rpa_pkg::bk_state_t state_reg;
    rpa_pkg::bk_state_t state_next;
    rpa_pkg::cmd_t      cmd_reg;
    rpa_pkg::cmd_t      cmd_next;
    logic [FW-1:0]      free_count_reg;
    logic [FW-1:0]      free_count_next;
    logic [FW-1:0]      min_count_reg;
    logic [FW-1:0]      min_count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [PW-1:0]      m_result_page_reg;
    logic [PW-1:0]      m_result_page_next;
    rpa_pkg::status_t   m_status_reg;
    rpa_pkg::status_t   m_status_next;
    logic               m_released_reg;
    logic               m_released_next;

    logic          cnt_we;
    logic [PW-1:0] cnt_waddr;
    logic [RW-1:0] cnt_wdata;
    logic [PW-1:0] cnt_raddr;
    logic [RW-1:0] cnt_rdata;
    logic          stk_we;
    logic [PW-1:0] stk_waddr;
    logic [PW-1:0] stk_wdata;
    logic [PW-1:0] stk_rdata;

    logic [FW-1:0] top_idx;
    logic [RW-1:0] cnt_cur;
    logic [PW-1:0] stk_cur;
    logic          stack_empty;
    logic          stack_full;

    rpa_ram #(
        .WIDTH (RW),
        .DEPTH (rpa_pkg::STORE_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (PW),
        .DEPTH (rpa_pkg::STORE_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (top_idx[PW-1:0]),
        .rdata (stk_rdata)
    );

    // Entries below the lowest stack depth ever reached still hold their reset
    // values, so the memories are read through that mark instead of cleared.
    assign top_idx     = free_count_reg - FW'(1);
    assign cnt_raddr   = cmd.page;
    assign cnt_cur     = ({1'b0, cmd_reg.page_idx} >= min_count_reg) ? cnt_rdata : '0;
    assign stk_cur     = (top_idx < min_count_reg)
                         ? (PW'(FIRST_PAGE) + top_idx[PW-1:0]) : stk_rdata;
    assign stack_empty = free_count_reg == '0;
    assign stack_full  = free_count_reg == FW'(rpa_pkg::STORE_DEPTH);

    always_comb begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        free_count_next    = free_count_reg;
        min_count_next     = min_count_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_result_page_next = m_result_page_reg;
        m_status_next      = m_status_reg;
        m_released_next    = m_released_reg;
        cmd_ready          = 1'b0;
        cnt_we             = 1'b0;
        cnt_waddr          = cmd_reg.page;
        cnt_wdata          = '0;
        stk_we             = 1'b0;
        stk_waddr          = free_count_reg[PW-1:0];
        stk_wdata          = cmd_reg.page;

        unique case (state_reg)
            rpa_pkg::BK_IDLE: begin
                if (cmd_valid && (!m_valid_reg || m_ready)) begin
                    cmd_ready  = 1'b1;
                    cmd_next   = cmd;
                    state_next = rpa_pkg::BK_EXEC;
                end
            end

            rpa_pkg::BK_EXEC: begin
                m_result_page_next = '0;
                m_status_next      = rpa_pkg::STATUS_OK;
                m_released_next    = 1'b0;
                state_next         = rpa_pkg::BK_IDLE;
                m_valid_next       = 1'b1;
                if (cmd_reg.op != rpa_pkg::OP_ALLOC && cmd_reg.out_of_range) begin
                    m_status_next = rpa_pkg::STATUS_RANGE;
                end else begin
                    unique case (cmd_reg.op)
                        rpa_pkg::OP_ALLOC: begin
                            if (stack_empty) begin
                                m_status_next = rpa_pkg::STATUS_EMPTY;
                            end else begin
                                m_result_page_next = stk_cur;
                                cnt_we             = 1'b1;
                                cnt_waddr          = stk_cur;
                                cnt_wdata          = RW'(1);
                                free_count_next    = top_idx;
                                if (top_idx < min_count_reg) begin
                                    min_count_next = top_idx;
                                end
                            end
                        end
                        rpa_pkg::OP_FREE: begin
                            if (cnt_cur == '0) begin
                                m_status_next = rpa_pkg::STATUS_COUNT;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_cur - RW'(1);
                                if (cnt_cur == RW'(1) && !stack_full) begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + FW'(1);
                                    m_released_next = 1'b1;
                                end
                            end
                        end
                        rpa_pkg::OP_ADDREF: begin
                            if (cnt_cur == '0 || cnt_cur == rpa_pkg::RCOUNT_MAX) begin
                                m_status_next = rpa_pkg::STATUS_COUNT;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_cur + RW'(1);
                            end
                        end
                        rpa_pkg::OP_SPLIT: begin
                            if (cnt_cur <= RW'(1)) begin
                                m_result_page_next = cmd_reg.page;
                            end else if (stack_empty) begin
                                m_status_next = rpa_pkg::STATUS_EMPTY;
                            end else begin
                                m_result_page_next = stk_cur;
                                cnt_we             = 1'b1;
                                cnt_wdata          = cnt_cur - RW'(1);
                                free_count_next    = top_idx;
                                if (top_idx < min_count_reg) begin
                                    min_count_next = top_idx;
                                end
                                m_valid_next = 1'b0;
                                state_next   = rpa_pkg::BK_SPLIT;
                            end
                        end
                        default: begin
                            m_status_next = rpa_pkg::STATUS_COUNT;
                        end
                    endcase
                end
            end

            rpa_pkg::BK_SPLIT: begin
                cnt_we       = 1'b1;
                cnt_waddr    = m_result_page_reg;
                cnt_wdata    = RW'(1);
                m_valid_next = 1'b1;
                state_next   = rpa_pkg::BK_IDLE;
            end

            default: begin
                state_next = rpa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rpa_pkg::BK_IDLE;
            free_count_reg <= FW'(INIT_COUNT);
            min_count_reg  <= FW'(INIT_COUNT);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            min_count_reg  <= min_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg           <= cmd_next;
        m_result_page_reg <= m_result_page_next;
        m_status_reg      <= m_status_next;
        m_released_reg    <= m_released_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_page = m_result_page_reg;
    assign m_status      = m_status_reg;
    assign m_released    = m_released_reg;
    assign free_count    = free_count_reg;

endmodule

>>> hw/rtl/refcounted_page_allocator_top.sv
// Reference-counted page allocator: each request word yields exactly one
// result word, in order. A request passes through an idle state that reads
// the count and stack memories and an execution state that updates them; a
// copy-on-write split that hands out a fresh page adds a split state, since
// the count memory has a single write port and both the old and new page
// counts change. A two-entry queue sits between decode and execution and the
// result is held in an output register, so the queue still takes up to two
// requests while a result waits. There is no clearing pass after reset: reset
// contents of both memories are reconstructed from the lowest stack depth
// reached since reset, so the block accepts requests straight out of reset.
// ----------------------------------------------------------------------------
// Page allocator top level
// Free-list page allocator with reference counts and copy-on-write split.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_page_allocator_top #(
    parameter int NUM_PAGES  = 32768,
    parameter int FIRST_PAGE = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [rpa_pkg::PAGE_W-1:0] s_page,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rpa_pkg::PAGE_W-1:0] m_result_page,
    output logic [1:0]                 m_status,
    output logic                       m_released
);

    localparam int USABLE_END = (NUM_PAGES < rpa_pkg::STORE_DEPTH)
                                ? NUM_PAGES : rpa_pkg::STORE_DEPTH;
    localparam int INIT_COUNT = (FIRST_PAGE < USABLE_END) ? (USABLE_END - FIRST_PAGE) : 0;

    logic                         fe_valid;
    logic                         fe_ready;
    rpa_pkg::cmd_t                fe_cmd;
    logic                         q_valid;
    logic                         q_ready;
    rpa_pkg::cmd_t                q_cmd;
    logic [rpa_pkg::FCOUNT_W-1:0] free_count;

    rpa_front #(
        .FIRST_PAGE (FIRST_PAGE),
        .USABLE_END (USABLE_END)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_page      (s_page),
        .cmd_valid   (fe_valid),
        .cmd_ready   (fe_ready),
        .cmd         (fe_cmd)
    );

    rpa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  (fe_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    rpa_back #(
        .FIRST_PAGE (FIRST_PAGE),
        .INIT_COUNT (INIT_COUNT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_page (m_result_page),
        .m_status      (m_status),
        .m_released    (m_released),
        .free_count    (free_count)
    );

    `ASSERT_IMPLY(a_release_ok, aclk, aresetn, m_valid && m_released, m_status == rpa_pkg::STATUS_OK, "release reported with a failing status")
    `ASSERT_IMPLY(a_fail_zero_page, aclk, aresetn, m_valid && (m_status != rpa_pkg::STATUS_OK), m_result_page == '0, "failing result carries a page")
    `ASSERT_ALWAYS(a_free_bound, aclk, aresetn, 32'(free_count) <= 32'(INIT_COUNT), "free stack holds more pages than exist")

endmodule
